### rtl/dbam_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and geometry functions of the block availability map.
// Used by disk_block_allocation_map_unit, the scoreboard and tb_top; depends on nothing.

package dbam_pkg;

   // Sizing
   localparam int MAX_TRACKS            = 80;
   localparam int MAX_SECTORS_PER_TRACK = 40;
   localparam int MAX_ALLOCATION        = 64;

   // Port field widths
   localparam int ACTION_W = 3;
   localparam int TRACK_W  = 7;
   localparam int SECTOR_W = 6;
   localparam int COUNT_W  = 7;
   localparam int FIT_W    = 6;
   localparam int TOTAL_W  = 12;
   localparam int IMG_W    = 2;

   // Derived storage widths
   localparam int SECT_BITS = MAX_SECTORS_PER_TRACK;
   localparam int CNT_W     = $clog2(MAX_SECTORS_PER_TRACK + 1);
   localparam int SIDX_W    = $clog2(MAX_SECTORS_PER_TRACK);
   localparam int ADDR_W    = $clog2(MAX_TRACKS);
   localparam int CMP_W     = 8;

   // Geometry codes
   localparam logic [IMG_W-1:0] IMG_NONE = 2'd0;
   localparam logic [IMG_W-1:0] IMG_35   = 2'd1;
   localparam logic [IMG_W-1:0] IMG_70   = 2'd2;
   localparam logic [IMG_W-1:0] IMG_80   = 2'd3;

   // Geometry constants
   localparam int TRACKS_35     = 35;
   localparam int TRACKS_70     = 70;
   localparam int TRACKS_80     = 80;
   localparam int ZONE1_SECTORS = 21;
   localparam int FLAT_SECTORS  = 40;
   localparam logic [TRACK_W-1:0] SIDE_TRACKS = 7'd35;
   localparam logic [TRACK_W-1:0] ZONE1_LAST  = 7'd17;
   localparam logic [TRACK_W-1:0] ZONE2_LAST  = 7'd24;
   localparam logic [TRACK_W-1:0] ZONE3_LAST  = 7'd30;
   localparam logic [TRACK_W-1:0] DIR_TRACK   = 7'd18;
   localparam logic [TRACK_W-1:0] DIR_TRACK_B = 7'd53;
   localparam logic [TRACK_W-1:0] HDR_TRACK   = 7'd40;

   typedef enum logic [ACTION_W-1:0] {
      ACT_QUERY     = 3'd0,
      ACT_MARK_USED = 3'd1,
      ACT_MARK_FREE = 3'd2,
      ACT_ALLOC     = 3'd3,
      ACT_FORMAT    = 3'd4
   } action_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD,
      ST_RPT,
      ST_FMT_WR,
      ST_A1_RD,
      ST_A1_LOAD,
      ST_A1_SCAN,
      ST_A2_RD,
      ST_A2_LOAD,
      ST_A2_TAKE,
      ST_A2_EMIT
   } state_type;

   // One map entry: free count and free bits of a track
   typedef struct packed {
      logic [CNT_W-1:0]     cnt;
      logic [SECT_BITS-1:0] bits;
   } trk_word_type;

   localparam int WORD_W = $bits(trk_word_type);

   function automatic logic [TRACK_W-1:0] track_limit(input logic [IMG_W-1:0] img);
      logic [7:0] n;
      unique case (img)
         IMG_35:  n = 8'(TRACKS_35);
         IMG_70:  n = 8'(TRACKS_70);
         IMG_80:  n = 8'(TRACKS_80);
         default: n = '0;
      endcase
      if (n > 8'(MAX_TRACKS)) n = 8'(MAX_TRACKS);
      return TRACK_W'(n);
   endfunction

   function automatic logic track_ok(input logic [IMG_W-1:0] img,
                                     input logic [TRACK_W-1:0] t);
      return (t != '0) && (t <= track_limit(img));
   endfunction

   function automatic logic [CNT_W-1:0] sectors_in(input logic [IMG_W-1:0] img,
                                                   input logic [TRACK_W-1:0] t);
      logic [TRACK_W-1:0] st;
      logic [TRACK_W-1:0] n;
      st = t;
      n  = '0;
      if (track_ok(img, t)) begin
         if (img == IMG_80) begin
            n = TRACK_W'(FLAT_SECTORS);
         end else begin
            if (img == IMG_70 && t > SIDE_TRACKS) st = t - SIDE_TRACKS;
            n = TRACK_W'(ZONE1_SECTORS);
            if (st > ZONE1_LAST) n = n - TRACK_W'(2);
            if (st > ZONE2_LAST) n = n - TRACK_W'(1);
            if (st > ZONE3_LAST) n = n - TRACK_W'(1);
         end
         if (n > TRACK_W'(MAX_SECTORS_PER_TRACK)) n = TRACK_W'(MAX_SECTORS_PER_TRACK);
      end
      return CNT_W'(n);
   endfunction

   function automatic logic [SECT_BITS-1:0] sect_mask(input logic [CNT_W-1:0] ns);
      logic [SECT_BITS-1:0] m;
      for (int i = 0; i < SECT_BITS; i++) m[i] = (ns > CNT_W'(i));
      return m;
   endfunction

   // Freshly formatted track: all valid sectors free except the directory/map ones
   function automatic trk_word_type fmt_word(input logic [IMG_W-1:0] img,
                                             input logic [TRACK_W-1:0] t);
      trk_word_type         w;
      logic [CNT_W-1:0]     ns;
      logic [SECT_BITS-1:0] rsv;
      logic [2:0]           nrsv;
      ns   = sectors_in(img, t);
      rsv  = '0;
      nrsv = '0;
      if ((img == IMG_35 || img == IMG_70) && t == DIR_TRACK) begin
         rsv[1:0] = 2'b11;
         nrsv     = 3'd2;
      end else if (img == IMG_70 && t == DIR_TRACK_B) begin
         rsv[0] = 1'b1;
         nrsv   = 3'd1;
      end else if (img == IMG_80 && t == HDR_TRACK) begin
         rsv[3:0] = 4'hF;
         nrsv     = 3'd4;
      end
      w.bits = sect_mask(ns) & ~rsv;
      w.cnt  = ns - CNT_W'(nrsv);
      return w;
   endfunction

   function automatic logic [SIDX_W-1:0] lsb_index(input logic [SECT_BITS-1:0] oh);
      logic [SIDX_W-1:0] idx;
      idx = '0;
      for (int i = 0; i < SECT_BITS; i++) begin
         if (oh[i]) idx = idx | SIDX_W'(i);
      end
      return idx;
   endfunction

endpackage

### rtl/dbam_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.

module dbam_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) mem_ff[wr_addr] <= wr_data;
      if (rd_en) rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/disk_block_allocation_map_unit.sv
`timescale 1ns / 1ps
// Top level of the block availability map: sequencer, find-lowest-set-bit unit,
// map RAM. Depends on dbam_pkg and dbam_ram.
//
// Usage
//   Request: drive req_action/req_track/req_sector/req_count and pulse start while
//   busy is low; the transaction is taken at that edge. busy stays high until the
//   last result has been registered.
//   Response: each result sits on the rsp_ ports for one cycle with rsp_valid high;
//   rsp_last marks the final one. The receiver cannot stall; nothing is held back.
//   Config: csr_wr_en/csr_wr_data write the geometry (image type) while idle.
// Sequence
//   Query, mark, unknown action and allocate with a count out of range: one result,
//   after the registered map RAM read (issued in ST_IDLE or ST_RD) and a
//   read-modify-write in ST_RPT; the next start is taken back in ST_IDLE.
//   Format: one RAM write per track of the geometry in ST_FMT_WR, then ST_RD, ST_RPT.
//   Allocate: the lowest-set-bit unit takes one free sector per cycle within a track.
//   A counting pass (ST_A1_RD, ST_A1_LOAD, ST_A1_SCAN per track visited) proves enough
//   are free, then a taking pass (ST_A2_RD, ST_A2_LOAD, ST_A2_TAKE, ST_A2_EMIT) writes
//   the map back and emits one result per sector. A short allocate ends after the
//   counting pass with one failure result.
// Reset: synchronous, active high; the map reads as all used (per-track valid bits
//   cleared), counts zero, geometry 35-track. No clearing pass is needed.

module disk_block_allocation_map_unit
   import dbam_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   // request
   input  logic                start,
   output logic                busy,
   input  logic [ACTION_W-1:0] req_action,
   input  logic [TRACK_W-1:0]  req_track,
   input  logic [SECTOR_W-1:0] req_sector,
   input  logic [COUNT_W-1:0]  req_count,
   // response
   output logic                rsp_valid,
   output logic                rsp_ok,
   output logic                rsp_is_free,
   output logic [TRACK_W-1:0]  rsp_out_track,
   output logic [SECTOR_W-1:0] rsp_out_sector,
   output logic [FIT_W-1:0]    rsp_free_in_track,
   output logic [TOTAL_W-1:0]  rsp_total_free,
   output logic                rsp_last,
   // configuration
   input  logic                csr_wr_en,
   input  logic [IMG_W-1:0]    csr_wr_data
);

   // ---------------------------------------------------------------------------
   // Registers
   // ---------------------------------------------------------------------------
   state_type            state_ff,  state_in;
   logic [IMG_W-1:0]     image_ff,  image_in;
   logic [MAX_TRACKS-1:0] valid_ff, valid_in;   // map entry written since reset/format
   logic                 rd_vld_ff, rd_vld_in;  // valid bit of the entry just read
   logic [TOTAL_W-1:0]   total_ff,  total_in;
   logic [TRACK_W-1:0]   cur_ff,    cur_in;     // track cursor for format/allocate
   logic [COUNT_W-1:0]   rem_ff,    rem_in;     // sectors still to find/take

   logic [ACTION_W-1:0]  act_ff,    act_in;
   logic [TRACK_W-1:0]   trk_ff,    trk_in;
   logic [SECTOR_W-1:0]  sec_ff,    sec_in;
   logic [COUNT_W-1:0]   num_ff,    num_in;
   logic [SECT_BITS-1:0] work_ff,   work_in;    // operand of the lowest-bit unit
   logic [SECT_BITS-1:0] old_ff,    old_in;     // track bits being consumed
   logic [SECT_BITS-1:0] taken_ff,  taken_in;   // bits taken from this track
   logic [CNT_W-1:0]     tcnt_ff,   tcnt_in;    // running free count of this track

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 rsp_ok_ff,    rsp_ok_in;
   logic                 rsp_isf_ff,   rsp_isf_in;
   logic [TRACK_W-1:0]   rsp_trk_ff,   rsp_trk_in;
   logic [SECTOR_W-1:0]  rsp_sec_ff,   rsp_sec_in;
   logic [FIT_W-1:0]     rsp_fit_ff,   rsp_fit_in;
   logic [TOTAL_W-1:0]   rsp_tot_ff,   rsp_tot_in;
   logic                 rsp_last_ff,  rsp_last_in;

   // ---------------------------------------------------------------------------
   // Map RAM: one word per track
   // ---------------------------------------------------------------------------
   logic              ram_wr_en, ram_rd_en;
   logic [ADDR_W-1:0] ram_wr_addr, ram_rd_addr;
   trk_word_type      ram_wr_word, ram_rd_word, eff_word;
   logic [WORD_W-1:0] ram_rd_data;

   dbam_ram #(
      .WIDTH (WORD_W),
      .DEPTH (MAX_TRACKS)
   ) u_map_ram (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_word),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   assign ram_rd_word = ram_rd_data;
   // entries not written since reset/format read as all used
   assign eff_word    = rd_vld_ff ? ram_rd_word : '0;

   // ---------------------------------------------------------------------------
   // Shared unit: isolate and clear the lowest set bit of work_ff
   // ---------------------------------------------------------------------------
   logic [SECT_BITS-1:0] lb_clear, lb_onehot;
   logic [SIDX_W-1:0]    lb_idx;

   assign lb_clear  = work_ff & (work_ff - SECT_BITS'(1));
   assign lb_onehot = work_ff ^ lb_clear;
   assign lb_idx    = lsb_index(lb_onehot);

   // ---------------------------------------------------------------------------
   // Misc decode
   // ---------------------------------------------------------------------------
   logic [TRACK_W-1:0] limit;
   logic               req_num_ok;
   logic               cur_in_geom;
   logic [ADDR_W-1:0]  cur_addr;
   trk_word_type       fmt_cur;
   logic [SECT_BITS-1:0] cur_mask;

   assign limit       = track_limit(image_ff);
   assign req_num_ok  = (req_count != '0) && (req_count <= COUNT_W'(MAX_ALLOCATION));
   assign cur_in_geom = (cur_ff <= limit);
   assign cur_addr    = ADDR_W'(cur_ff - TRACK_W'(1));
   assign fmt_cur     = fmt_word(image_ff, cur_ff);
   assign cur_mask    = sect_mask(sectors_in(image_ff, cur_ff));

   // Single-result report: apply a mark to the word just read, then report
   logic                 rpt_trk_ok, rpt_sv, rpt_hit, rpt_is_mark, rpt_ok;
   logic [CNT_W-1:0]     rpt_ns;
   logic [SECT_BITS-1:0] rpt_oh, rpt_bits;
   logic [CNT_W-1:0]     rpt_cnt;
   logic [TOTAL_W-1:0]   rpt_total;

   always_comb begin
      rpt_trk_ok  = track_ok(image_ff, trk_ff);
      rpt_ns      = sectors_in(image_ff, trk_ff);
      rpt_sv      = rpt_trk_ok && (CMP_W'(sec_ff) < CMP_W'(rpt_ns));
      rpt_oh      = SECT_BITS'(1) << sec_ff;
      rpt_hit     = |(eff_word.bits & rpt_oh);
      rpt_is_mark = (act_ff == ACT_MARK_USED) || (act_ff == ACT_MARK_FREE);
      rpt_bits    = eff_word.bits;
      rpt_cnt     = eff_word.cnt;
      rpt_total   = total_ff;
      if (rpt_sv && act_ff == ACT_MARK_USED && rpt_hit) begin
         rpt_bits  = eff_word.bits & ~rpt_oh;
         rpt_cnt   = eff_word.cnt - CNT_W'(1);
         rpt_total = total_ff - TOTAL_W'(1);
      end else if (rpt_sv && act_ff == ACT_MARK_FREE && !rpt_hit) begin
         rpt_bits  = eff_word.bits | rpt_oh;
         rpt_cnt   = eff_word.cnt + CNT_W'(1);
         rpt_total = total_ff + TOTAL_W'(1);
      end
      unique case (act_ff)
         ACT_QUERY, ACT_MARK_USED, ACT_MARK_FREE: rpt_ok = rpt_sv;
         ACT_FORMAT:                              rpt_ok = (image_ff != IMG_NONE);
         default:                                 rpt_ok = 1'b0;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Next state
   // ---------------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               if (req_action == ACT_FORMAT)                   state_in = ST_FMT_WR;
               else if (req_action == ACT_ALLOC && req_num_ok) state_in = ST_A1_RD;
               else                                            state_in = ST_RPT;
            end
         end
         ST_RD:      state_in = ST_RPT;
         ST_RPT:     state_in = ST_IDLE;
         ST_FMT_WR:  if (!cur_in_geom) state_in = ST_RD;
         ST_A1_RD:   state_in = cur_in_geom ? ST_A1_LOAD : ST_RD;
         ST_A1_LOAD: state_in = ST_A1_SCAN;
         ST_A1_SCAN: begin
            if (work_ff == '0)              state_in = ST_A1_RD;
            else if (rem_ff == COUNT_W'(1)) state_in = ST_A2_RD;
         end
         ST_A2_RD:   state_in = ST_A2_LOAD;
         ST_A2_LOAD: state_in = ST_A2_TAKE;
         ST_A2_TAKE: begin
            if (work_ff == '0 || rem_ff == '0)
               state_in = (taken_ff == '0) ? ST_A2_RD : ST_A2_EMIT;
         end
         ST_A2_EMIT: begin
            if (lb_clear == '0) state_in = (rem_ff == '0) ? ST_IDLE : ST_A2_RD;
         end
         default:    state_in = ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------------
   // Datapath, RAM control and results
   // ---------------------------------------------------------------------------
   always_comb begin
      image_in     = csr_wr_en ? csr_wr_data : image_ff;
      valid_in     = valid_ff;
      total_in     = total_ff;
      cur_in       = cur_ff;
      rem_in       = rem_ff;
      act_in       = act_ff;
      trk_in       = trk_ff;
      sec_in       = sec_ff;
      num_in       = num_ff;
      work_in      = work_ff;
      old_in       = old_ff;
      taken_in     = taken_ff;
      tcnt_in      = tcnt_ff;
      rsp_valid_in = 1'b0;
      rsp_ok_in    = rsp_ok_ff;
      rsp_isf_in   = rsp_isf_ff;
      rsp_trk_in   = rsp_trk_ff;
      rsp_sec_in   = rsp_sec_ff;
      rsp_fit_in   = rsp_fit_ff;
      rsp_tot_in   = rsp_tot_ff;
      rsp_last_in  = rsp_last_ff;
      ram_wr_en    = 1'b0;
      ram_wr_addr  = '0;
      ram_wr_word  = '0;
      ram_rd_en    = 1'b0;
      ram_rd_addr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               act_in = req_action;
               trk_in = req_track;
               sec_in = req_sector;
               num_in = req_count;
               rem_in = req_count;
               cur_in = TRACK_W'(1);
               if (req_action == ACT_FORMAT) begin
                  valid_in = '0;
                  total_in = '0;
               end else if (!(req_action == ACT_ALLOC && req_num_ok)) begin
                  ram_rd_en   = 1'b1;
                  ram_rd_addr = track_ok(image_ff, req_track) ?
                                ADDR_W'(req_track - TRACK_W'(1)) : '0;
               end
            end
         end
         ST_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = track_ok(image_ff, trk_ff) ? ADDR_W'(trk_ff - TRACK_W'(1)) : '0;
         end
         ST_RPT: begin
            if (rpt_sv && rpt_is_mark) begin
               ram_wr_en        = 1'b1;
               ram_wr_addr      = ADDR_W'(trk_ff - TRACK_W'(1));
               ram_wr_word.bits = rpt_bits;
               ram_wr_word.cnt  = rpt_cnt;
            end
            total_in     = rpt_total;
            rsp_valid_in = 1'b1;
            rsp_ok_in    = rpt_ok;
            rsp_isf_in   = rpt_sv && |(rpt_bits & rpt_oh);
            rsp_trk_in   = trk_ff;
            rsp_sec_in   = sec_ff;
            rsp_fit_in   = rpt_trk_ok ? FIT_W'(rpt_cnt) : '0;
            rsp_tot_in   = rpt_total;
            rsp_last_in  = 1'b1;
         end
         ST_FMT_WR: begin
            if (cur_in_geom) begin
               ram_wr_en   = 1'b1;
               ram_wr_addr = cur_addr;
               ram_wr_word = fmt_cur;
               total_in    = total_ff + TOTAL_W'(fmt_cur.cnt);
               cur_in      = cur_ff + TRACK_W'(1);
            end
         end
         ST_A1_RD: begin
            if (cur_in_geom) begin
               ram_rd_en   = 1'b1;
               ram_rd_addr = cur_addr;
            end
         end
         ST_A1_LOAD: work_in = eff_word.bits & cur_mask;
         ST_A1_SCAN: begin
            // counting pass: the map RAM is not written
            if (work_ff == '0) begin
               cur_in = cur_ff + TRACK_W'(1);
            end else if (rem_ff == COUNT_W'(1)) begin
               cur_in   = TRACK_W'(1);
               rem_in   = num_ff;
               total_in = total_ff - TOTAL_W'(num_ff);
            end else begin
               work_in = lb_clear;
               rem_in  = rem_ff - COUNT_W'(1);
            end
         end
         ST_A2_RD: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = cur_addr;
         end
         ST_A2_LOAD: begin
            old_in   = eff_word.bits;
            tcnt_in  = eff_word.cnt;
            work_in  = eff_word.bits & cur_mask;
            taken_in = '0;
         end
         ST_A2_TAKE: begin
            if (work_ff == '0 || rem_ff == '0) begin
               ram_wr_en        = 1'b1;
               ram_wr_addr      = cur_addr;
               ram_wr_word.bits = old_ff;
               ram_wr_word.cnt  = tcnt_ff;
               work_in          = taken_ff;
               if (taken_ff == '0) cur_in = cur_ff + TRACK_W'(1);
            end else begin
               taken_in = taken_ff | lb_onehot;
               old_in   = old_ff & ~lb_onehot;
               tcnt_in  = tcnt_ff - CNT_W'(1);
               work_in  = lb_clear;
               rem_in   = rem_ff - COUNT_W'(1);
            end
         end
         ST_A2_EMIT: begin
            // track count is final here: taking from this track finished above
            rsp_valid_in = 1'b1;
            rsp_ok_in    = 1'b1;
            rsp_isf_in   = 1'b0;
            rsp_trk_in   = cur_ff;
            rsp_sec_in   = SECTOR_W'(lb_idx);
            rsp_fit_in   = FIT_W'(tcnt_ff);
            rsp_tot_in   = total_ff;
            rsp_last_in  = (lb_clear == '0) && (rem_ff == '0);
            work_in      = lb_clear;
            if (lb_clear == '0 && rem_ff != '0) cur_in = cur_ff + TRACK_W'(1);
         end
         default: ;
      endcase

      if (ram_wr_en) valid_in[ram_wr_addr] = 1'b1;
      rd_vld_in = ram_rd_en ? valid_in[ram_rd_addr] : rd_vld_ff;
   end

   // ---------------------------------------------------------------------------
   // Sequential
   // ---------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         image_ff     <= IMG_35;
         valid_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         total_ff     <= '0;
         cur_ff       <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         image_ff     <= image_in;
         valid_ff     <= valid_in;
         rd_vld_ff    <= rd_vld_in;
         total_ff     <= total_in;
         cur_ff       <= cur_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      act_ff      <= act_in;
      trk_ff      <= trk_in;
      sec_ff      <= sec_in;
      num_ff      <= num_in;
      work_ff     <= work_in;
      old_ff      <= old_in;
      taken_ff    <= taken_in;
      tcnt_ff     <= tcnt_in;
      rsp_ok_ff   <= rsp_ok_in;
      rsp_isf_ff  <= rsp_isf_in;
      rsp_trk_ff  <= rsp_trk_in;
      rsp_sec_ff  <= rsp_sec_in;
      rsp_fit_ff  <= rsp_fit_in;
      rsp_tot_ff  <= rsp_tot_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_ok            = rsp_ok_ff;
   assign rsp_is_free       = rsp_isf_ff;
   assign rsp_out_track     = rsp_trk_ff;
   assign rsp_out_sector    = rsp_sec_ff;
   assign rsp_free_in_track = rsp_fit_ff;
   assign rsp_total_free    = rsp_tot_ff;
   assign rsp_last          = rsp_last_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted transaction did not raise busy");

   a_last_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> !busy)
      else $error("still busy after final result");

   a_mid_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("allocation run ended before its final result");

   a_fail_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ok |-> rsp_last)
      else $error("failure result not marked last");

   a_total_bound: assert property (@(posedge clock) disable iff (reset)
      total_ff <= TOTAL_W'(MAX_TRACKS * MAX_SECTORS_PER_TRACK))
      else $error("disk free total exceeds disk size");

endmodule

### verif/dbam_map_scoreboard_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the block availability map: shadow copy of the map, predicted results, checks.
// Depends on dbam_pkg for widths, geometry codes and action codes.

package dbam_map_scoreboard_pkg;
   import dbam_pkg::*;

   typedef struct packed {
      logic                ok;
      logic                is_free;
      logic [TRACK_W-1:0]  trk;
      logic [SECTOR_W-1:0] sec;
      logic [FIT_W-1:0]    fit;
      logic [TOTAL_W-1:0]  total;
      logic                last;
   } map_result_type;

   class alloc_map_scoreboard;
      logic [SECT_BITS-1:0] free_bits [MAX_TRACKS];
      int unsigned          trk_free  [MAX_TRACKS];
      int unsigned          disk_free;
      logic [IMG_W-1:0]     geometry;
      map_result_type       pending_map_results [$];
      int unsigned          errors;

      function new();
         clear_map();
         geometry = IMG_35;
         errors   = 0;
      endfunction

      function void clear_map();
         for (int i = 0; i < MAX_TRACKS; i++) begin
            free_bits[i] = '0;
            trk_free[i]  = 0;
         end
         disk_free = 0;
      endfunction

      function void apply_geometry(logic [IMG_W-1:0] g);
         geometry = g;
      endfunction

      function int unsigned pending();
         return pending_map_results.size();
      endfunction

      function int unsigned track_count();
         int unsigned n;
         case (geometry)
            IMG_35:  n = TRACKS_35;
            IMG_70:  n = TRACKS_70;
            IMG_80:  n = TRACKS_80;
            default: n = 0;
         endcase
         if (n > MAX_TRACKS) n = MAX_TRACKS;
         return n;
      endfunction

      function int unsigned sector_count(int unsigned t);
         int unsigned st;
         int unsigned n;
         if (t < 1 || t > track_count()) return 0;
         if (geometry == IMG_80) begin
            n = FLAT_SECTORS;
         end else begin
            // second side repeats the zones of the first
            st = (geometry == IMG_70 && t > TRACKS_35) ? t - TRACKS_35 : t;
            n  = ZONE1_SECTORS;
            if (st > ZONE1_LAST) n = n - 2;
            if (st > ZONE2_LAST) n = n - 1;
            if (st > ZONE3_LAST) n = n - 1;
         end
         if (n > MAX_SECTORS_PER_TRACK) n = MAX_SECTORS_PER_TRACK;
         return n;
      endfunction

      function bit sector_valid(int unsigned t, int unsigned s);
         return s < sector_count(t);
      endfunction

      function bit set_sector(int unsigned t, int unsigned s, bit used);
         if (!sector_valid(t, s)) return 0;
         if (used && free_bits[t-1][s]) begin
            free_bits[t-1][s] = 1'b0;
            trk_free[t-1]--;
            disk_free--;
         end else if (!used && !free_bits[t-1][s]) begin
            free_bits[t-1][s] = 1'b1;
            trk_free[t-1]++;
            disk_free++;
         end
         return 1;
      endfunction

      function void push_result(bit ok, bit isf, int unsigned t, int unsigned s,
                                int unsigned fit, bit last);
         map_result_type r;
         r.ok      = ok;
         r.is_free = isf;
         r.trk     = TRACK_W'(t);
         r.sec     = SECTOR_W'(s);
         r.fit     = FIT_W'(fit);
         r.total   = TOTAL_W'(disk_free);
         r.last    = last;
         pending_map_results = {pending_map_results, r};
      endfunction

      function void push_report(bit ok, int unsigned t, int unsigned s);
         int unsigned fit;
         bit          isf;
         fit = (t >= 1 && t <= track_count()) ? trk_free[t-1] : 0;
         isf = sector_valid(t, s) ? free_bits[t-1][s] : 1'b0;
         push_result(ok, isf, t, s, fit, 1'b1);
      endfunction

      function bit format_map();
         int unsigned n;
         clear_map();
         for (int unsigned t = 1; t <= track_count(); t++) begin
            n = sector_count(t);
            for (int unsigned s = 0; s < n; s++) free_bits[t-1][s] = 1'b1;
            trk_free[t-1] = n;
            disk_free     = disk_free + n;
         end
         // directory and map sectors
         if (geometry == IMG_35 || geometry == IMG_70) begin
            void'(set_sector(DIR_TRACK, 0, 1'b1));
            void'(set_sector(DIR_TRACK, 1, 1'b1));
            if (geometry == IMG_70) void'(set_sector(DIR_TRACK_B, 0, 1'b1));
         end else if (geometry == IMG_80) begin
            for (int unsigned s = 0; s < 4; s++) void'(set_sector(HDR_TRACK, s, 1'b1));
         end
         return geometry != IMG_NONE;
      endfunction

      function void allocate_run(int unsigned n, int unsigned t0, int unsigned s0);
         int unsigned take_trk [$];
         int unsigned take_sec [$];
         int unsigned ns;
         if (n == 0 || n > MAX_ALLOCATION) begin
            push_report(1'b0, t0, s0);
            return;
         end
         // first fit: track order, then sector order
         for (int unsigned t = 1; t <= track_count() && take_trk.size() < n; t++) begin
            ns = sector_count(t);
            for (int unsigned s = 0; s < ns && take_trk.size() < n; s++) begin
               if (free_bits[t-1][s]) begin
                  take_trk = {take_trk, t};
                  take_sec = {take_sec, s};
               end
            end
         end
         if (take_trk.size() < n) begin
            push_report(1'b0, t0, s0);
            return;
         end
         foreach (take_trk[k]) void'(set_sector(take_trk[k], take_sec[k], 1'b1));
         // track counts are reported after the whole run is taken
         foreach (take_trk[k])
            push_result(1'b1, 1'b0, take_trk[k], take_sec[k], trk_free[take_trk[k]-1],
                        k + 1 == n);
      endfunction

      function void note_request(logic [ACTION_W-1:0] action, logic [TRACK_W-1:0] trk,
                                 logic [SECTOR_W-1:0] sec, logic [COUNT_W-1:0] cnt);
         bit ok;
         case (action)
            ACT_QUERY: push_report(sector_valid(trk, sec), trk, sec);
            ACT_MARK_USED, ACT_MARK_FREE: begin
               ok = set_sector(trk, sec, action == ACT_MARK_USED);
               push_report(ok, trk, sec);
            end
            ACT_ALLOC: allocate_run(cnt, trk, sec);
            ACT_FORMAT: begin
               ok = format_map();
               push_report(ok, trk, sec);
            end
            default: push_report(1'b0, trk, sec);
         endcase
      endfunction

      function void compare_field(string name, logic [15:0] want, logic [15:0] got);
         if (got !== want) begin
            $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
            errors++;
         end
      endfunction

      function void check_result(map_result_type got);
         map_result_type want;
         if (pending_map_results.size() == 0) begin
            $display("%0t: unexpected result: expected none, actual track %0d sector %0d",
                     $time, got.trk, got.sec);
            errors++;
            return;
         end
         want = pending_map_results.pop_front();
         compare_field("ok",            want.ok,      got.ok);
         compare_field("is_free",       want.is_free, got.is_free);
         compare_field("out_track",     want.trk,     got.trk);
         compare_field("out_sector",    want.sec,     got.sec);
         compare_field("free_in_track", want.fit,     got.fit);
         compare_field("total_free",    want.total,   got.total);
         compare_field("last",          want.last,    got.last);
      endfunction
   endclass

endpackage

### verif/tb_top.sv
`timescale 1ns / 1ps
// Top of the block availability map testbench: clock, reset, request driver, result monitor.
// Depends on dbam_pkg, dbam_map_scoreboard_pkg and disk_block_allocation_map_unit.

module tb_top;
   import dbam_pkg::*;
   import dbam_map_scoreboard_pkg::*;

   localparam int          HALF_PERIOD  = 6;          // 12 ns clock
   localparam int unsigned CYCLE_LIMIT  = 1_000_000;  // watchdog limit on the whole simulation
   localparam int          TAIL_CYCLES  = 20;
   localparam int          PHASES       = 8;
   localparam int          PHASE_ITEMS  = 16;

   // actions the block must reject
   localparam logic [ACTION_W-1:0] ACT_RESERVED_LO = 3'd5;
   localparam logic [ACTION_W-1:0] ACT_RESERVED_HI = 3'd7;

   logic                clock;
   logic                reset;
   logic                start;
   logic                busy;
   logic [ACTION_W-1:0] req_action;
   logic [TRACK_W-1:0]  req_track;
   logic [SECTOR_W-1:0] req_sector;
   logic [COUNT_W-1:0]  req_count;
   logic                rsp_valid;
   logic                rsp_ok;
   logic                rsp_is_free;
   logic [TRACK_W-1:0]  rsp_out_track;
   logic [SECTOR_W-1:0] rsp_out_sector;
   logic [FIT_W-1:0]    rsp_free_in_track;
   logic [TOTAL_W-1:0]  rsp_total_free;
   logic                rsp_last;
   logic                csr_wr_en;
   logic [IMG_W-1:0]    csr_wr_data;

   alloc_map_scoreboard map_sb;
   map_result_type      seen;
   int unsigned         cycle_count = 0;
   int unsigned         idle_pct    = 0;   // chance in 100 that the sender leaves a gap before a request

   // Geometry per random phase; a format opens the phase where its bit is set.
   // Phase 4 runs on the map that the unknown geometry format cleared (sparse map,
   // short allocations); phase 7 keeps the 70-track map under 35-track geometry.
   logic [IMG_W-1:0] plan_geom [PHASES];
   localparam logic [PHASES-1:0] PLAN_FORMAT = 8'b0110_1111;

   disk_block_allocation_map_unit uut (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_action        (req_action),
      .req_track         (req_track),
      .req_sector        (req_sector),
      .req_count         (req_count),
      .rsp_valid         (rsp_valid),
      .rsp_ok            (rsp_ok),
      .rsp_is_free       (rsp_is_free),
      .rsp_out_track     (rsp_out_track),
      .rsp_out_sector    (rsp_out_sector),
      .rsp_free_in_track (rsp_free_in_track),
      .rsp_total_free    (rsp_total_free),
      .rsp_last          (rsp_last),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Watchdog: a hung handshake or a lost result ends up here.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("tb_top: errors");
         $finish;
      end
   end

   // Result monitor. Sampled right after the edge, so these are the values the
   // edge itself saw. The receiver cannot stall, so every strobe is a result;
   // an X strobe counts as one too.
   always @(posedge clock) begin
      if (!reset && rsp_valid !== 1'b0) begin
         seen.ok      = rsp_ok;
         seen.is_free = rsp_is_free;
         seen.trk     = rsp_out_track;
         seen.sec     = rsp_out_sector;
         seen.fit     = rsp_free_in_track;
         seen.total   = rsp_total_free;
         seen.last    = rsp_last;
         map_sb.check_result(seen);
      end
   end

   // One request transaction. Called right after a rising edge. Here start is only
   // lowered when a gap is taken, so back-to-back transactions keep it high and
   // no step sees two assignments to it.
   task automatic issue(input logic [ACTION_W-1:0] act, input logic [TRACK_W-1:0] trk,
                        input logic [SECTOR_W-1:0] sec, input logic [COUNT_W-1:0] cnt);
      if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      start      <= 1'b1;
      req_action <= act;
      req_track  <= trk;
      req_sector <= sec;
      req_count  <= cnt;
      // taken at the first edge with start high and busy low
      do @(posedge clock); while (busy !== 1'b0);
      map_sb.note_request(act, trk, sec, cnt);
   endtask

   // Hold off the sender until every predicted result is in and the block is idle.
   // Every transaction yields at least one result, so no extra settling is needed.
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (map_sb.pending() != 0 || busy !== 1'b0);
   endtask

   task automatic set_geometry(input logic [IMG_W-1:0] g);
      drain();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= g;
      @(posedge clock);
      map_sb.apply_geometry(g);
      csr_wr_en   <= 1'b0;
   endtask

   // Mostly well-formed: a valid address under the current geometry and a small
   // allocation; the rest is raw field noise and oversized counts.
   task automatic random_item();
      int unsigned         pick;
      int unsigned         nt;
      int unsigned         ns;
      logic [ACTION_W-1:0] act;
      logic [TRACK_W-1:0]  trk;
      logic [SECTOR_W-1:0] sec;
      logic [COUNT_W-1:0]  cnt;
      pick = $urandom_range(99);
      if (pick < 25)      act = ACT_QUERY;
      else if (pick < 45) act = ACT_MARK_USED;
      else if (pick < 65) act = ACT_MARK_FREE;
      else if (pick < 88) act = ACT_ALLOC;
      else if (pick < 93) act = ACT_FORMAT;
      else                act = ACTION_W'($urandom_range(ACT_RESERVED_HI, ACT_RESERVED_LO));
      nt = map_sb.track_count();
      if (nt != 0 && $urandom_range(9) < 8) begin
         trk = TRACK_W'($urandom_range(nt, 1));
         ns  = map_sb.sector_count(trk);
         sec = SECTOR_W'($urandom_range(ns - 1, 0));
      end else begin
         trk = TRACK_W'($urandom());
         sec = SECTOR_W'($urandom());
      end
      pick = $urandom_range(9);
      if (pick < 7)      cnt = COUNT_W'($urandom_range(8, 1));
      else if (pick < 9) cnt = COUNT_W'($urandom_range(MAX_ALLOCATION, 1));
      else               cnt = COUNT_W'($urandom());
      issue(act, trk, sec, cnt);
   endtask

   initial begin
      map_sb      = new();
      plan_geom   = '{IMG_35, IMG_80, IMG_70, IMG_NONE, IMG_35, IMG_80, IMG_70, IMG_35};
      reset       <= 1'b1;
      start       <= 1'b0;
      req_action  <= ACT_QUERY;
      req_track   <= '0;
      req_sector  <= '0;
      req_count   <= '0;
      csr_wr_en   <= 1'b0;
      csr_wr_data <= IMG_35;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // ---- directed part, reset geometry (35 tracks), map all used ----
      issue(ACT_QUERY, 1, 0, 1);
      issue(ACT_ALLOC, 0, 0, 1);                 // nothing free
      issue(ACT_MARK_FREE, 1, 0, 1);
      issue(ACT_MARK_FREE, 1, 0, 1);             // already free: counts must not move
      issue(ACT_ALLOC, 0, 0, 2);                 // one short: nothing taken
      issue(ACT_ALLOC, 0, 0, 1);                 // takes the single free sector
      issue(ACT_FORMAT, 0, 0, 1);
      issue(ACT_QUERY, DIR_TRACK, 1, 1);         // directory sector, used
      issue(ACT_QUERY, ZONE1_LAST, 20, 1);       // last sector of the widest zone
      issue(ACT_QUERY, ZONE1_LAST, 21, 1);       // one past it
      issue(ACT_MARK_USED, SIDE_TRACKS, 16, 1);
      issue(ACT_MARK_USED, SIDE_TRACKS, 16, 1);  // already used
      issue(ACT_QUERY, 0, 0, 1);                 // track 0 never valid
      issue(ACT_QUERY, '1, '1, '1);              // all fields at their maximum
      issue(ACT_RESERVED_LO, 1, 1, 1);
      issue(ACT_RESERVED_HI, 1, 1, 1);
      issue(ACT_ALLOC, 1, 2, 0);                 // zero count
      issue(ACT_ALLOC, 1, 2, MAX_ALLOCATION + 1);
      issue(ACT_ALLOC, 0, 0, MAX_ALLOCATION);    // largest legal run, crosses tracks

      set_geometry(IMG_NONE);
      issue(ACT_FORMAT, 0, 0, 1);                // fails, leaves the map all used
      issue(ACT_QUERY, 1, 0, 1);

      set_geometry(IMG_70);
      issue(ACT_FORMAT, 0, 0, 1);
      issue(ACT_QUERY, DIR_TRACK_B, 0, 1);       // second-side directory sector
      issue(ACT_QUERY, TRACKS_70, 16, 1);

      set_geometry(IMG_80);
      issue(ACT_FORMAT, 0, 0, 1);
      issue(ACT_QUERY, HDR_TRACK, 3, 1);
      issue(ACT_MARK_FREE, TRACKS_80, FLAT_SECTORS, 1);  // one past the flat track

      // ---- random part: phases cycle the sender gap rate ----
      for (int p = 0; p < PHASES; p++) begin
         set_geometry(plan_geom[p]);
         case (p % 3)
            0:       idle_pct = 0;
            1:       idle_pct = 71;
            default: idle_pct = 28;   // shared setting; the receiver side cannot stall
         endcase
         if (PLAN_FORMAT[p])
            issue(ACT_FORMAT, TRACK_W'($urandom()), SECTOR_W'($urandom()),
                  COUNT_W'($urandom()));
         for (int i = 0; i < PHASE_ITEMS; i++) begin
            // sender waits for the pipeline to empty now and then
            if ((p == 1 && i == PHASE_ITEMS / 2) || $urandom_range(15) == 0) drain();
            random_item();
         end
      end

      drain();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (map_sb.errors == 0 && map_sb.pending() == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule

### sim.f
rtl/dbam_pkg.sv
rtl/dbam_ram.sv
rtl/disk_block_allocation_map_unit.sv
verif/dbam_map_scoreboard_pkg.sv
verif/tb_top.sv
